// File: hdl/ordered_array_insert_delete_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ordered array block
// Concurrent checks clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ORDERED_ARRAY_INSERT_DELETE_MACROS_SVH
`define ORDERED_ARRAY_INSERT_DELETE_MACROS_SVH

// same-cycle implication
`define OAID_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define OAID_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/oaid_pkg.sv
// ----------------------------------------------------------------------------
// oaid_pkg
// Sizes, codes and request/response types of the ordered array block.
// ----------------------------------------------------------------------------
package oaid_pkg;

  localparam int DEPTH     = 128;
  localparam int WORD_BITS = 32;
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W     = $clog2(DEPTH + 1);

  localparam int ACTION_W = 4;
  localparam int FIELD_W  = 32;
  localparam int POS_W    = 8;
  localparam int STATUS_W = 3;
  localparam int NCOUNT_W = 8;
  localparam int WHERE_W  = 7;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INS_END    = 4'd0,
    ACT_INS_FRONT  = 4'd1,
    ACT_INS_BEFORE = 4'd2,
    ACT_INS_AFTER  = 4'd3,
    ACT_INS_AT     = 4'd4,
    ACT_DEL_VALUE  = 4'd5,
    ACT_DEL_AT     = 4'd6,
    ACT_DEL_LAST   = 4'd7,
    ACT_DEL_FIRST  = 4'd8
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  typedef struct packed {
    action_t                    action;
    logic signed [FIELD_W-1:0]  value;
    logic signed [FIELD_W-1:0]  key;
    logic        [POS_W-1:0]    position;
  } in_req_t;

  typedef struct packed {
    status_t               status;
    logic [NCOUNT_W-1:0]   new_count;
    logic [WHERE_W-1:0]    where;
  } out_rsp_t;

  function automatic word_t to_word(input logic [FIELD_W-1:0] v);
    logic [WORD_BITS+FIELD_W-1:0] ext;
    ext = {{WORD_BITS{1'b0}}, v};
    return ext[WORD_BITS-1:0];
  endfunction

endpackage

// File: hdl/oaid_ram.sv
// ----------------------------------------------------------------------------
// oaid_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module oaid_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/ordered_array_insert_delete.sv
// ----------------------------------------------------------------------------
// ordered_array_insert_delete
// Packed list of signed words in one RAM, with insert and delete commands.
// ----------------------------------------------------------------------------
// The list lives in a DEPTH-entry RAM with a registered read, so every
// search and every shift walks the entries one per cycle. A request that
// needs no walk (insert at end, delete last, any error found up front,
// unused action codes) goes straight from idle to the response state. A
// key search walks from the head until the key is found or the list ends,
// a shift up or down walks only the entries moved, and since a shift
// starts where the search stopped, search and shift together span at most
// the whole list. Only one request is in work at a time; a new request is
// taken as soon as the previous one has placed its response in the output
// register, even while that response still waits. The entry RAM needs no
// clearing after reset: only positions below the count are ever read.
// ----------------------------------------------------------------------------
module ordered_array_insert_delete
  import oaid_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_req,
  output logic     out_valid,
  input  logic     out_ready,
  output out_rsp_t out_rsp
);

`include "ordered_array_insert_delete_macros.svh"

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_SHUP,
    S_SHDN,
    S_RESP
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    ptr_r, ptr_nxt;
  logic [ADDR_W-1:0]   at_r, at_nxt;
  logic                pend_vld_r, pend_vld_nxt;
  logic [ADDR_W-1:0]   pend_addr_r, pend_addr_nxt;
  action_t             act_r, act_nxt;
  word_t               val_r, val_nxt;
  word_t               skey_r, skey_nxt;
  status_t             st_r, st_nxt;
  logic [ADDR_W-1:0]   where_r, where_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_rsp_t            out_rsp_r, out_rsp_nxt;

  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  word_t               wr_data;
  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr;
  word_t               rd_data;
  logic                full;
  logic                hit;

  oaid_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign full      = (count_r == CNT_W'(DEPTH));
  assign hit       = pend_vld_r && (rd_data == skey_r);
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    at_nxt        = at_r;
    pend_vld_nxt  = 1'b0;
    pend_addr_nxt = pend_addr_r;
    act_nxt       = act_r;
    val_nxt       = val_r;
    skey_nxt      = skey_r;
    st_nxt        = st_r;
    where_nxt     = where_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_rsp_nxt   = out_rsp_r;
    wr_en         = 1'b0;
    wr_addr       = at_r;
    wr_data       = val_r;
    rd_en         = 1'b0;
    rd_addr       = ADDR_W'(ptr_r);

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          act_nxt   = in_req.action;
          val_nxt   = to_word(in_req.value);
          st_nxt    = ST_OK;
          where_nxt = '0;
          state_nxt = S_RESP;
          case (in_req.action)
            ACT_INS_END: begin
              if (full) begin
                st_nxt = ST_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = ADDR_W'(count_r);
                wr_data   = to_word(in_req.value);
                count_nxt = count_r + 1'b1;
                where_nxt = ADDR_W'(count_r);
              end
            end
            ACT_INS_FRONT: begin
              if (full) begin
                st_nxt = ST_FULL;
              end else begin
                at_nxt    = '0;
                ptr_nxt   = count_r;
                state_nxt = S_SHUP;
              end
            end
            ACT_INS_BEFORE, ACT_INS_AFTER: begin
              if (count_r == '0) begin
                st_nxt = ST_NOTFOUND;
              end else begin
                skey_nxt  = to_word(in_req.key);
                ptr_nxt   = '0;
                state_nxt = S_SEARCH;
              end
            end
            ACT_INS_AT: begin
              if (full) begin
                st_nxt = ST_FULL;
              end else if (in_req.position > count_r) begin
                st_nxt = ST_BADPOS;
              end else begin
                at_nxt    = ADDR_W'(in_req.position);
                ptr_nxt   = count_r;
                state_nxt = S_SHUP;
              end
            end
            ACT_DEL_VALUE: begin
              if (count_r == '0) begin
                st_nxt = ST_NOTFOUND;
              end else begin
                skey_nxt  = to_word(in_req.value);
                ptr_nxt   = '0;
                state_nxt = S_SEARCH;
              end
            end
            ACT_DEL_AT: begin
              if (in_req.position >= count_r) begin
                st_nxt = ST_BADPOS;
              end else begin
                at_nxt    = ADDR_W'(in_req.position);
                ptr_nxt   = CNT_W'(in_req.position) + 1'b1;
                state_nxt = S_SHDN;
              end
            end
            ACT_DEL_LAST: begin
              if (count_r == '0) begin
                st_nxt = ST_EMPTY;
              end else begin
                count_nxt = count_r - 1'b1;
                where_nxt = ADDR_W'(count_r - 1'b1);
              end
            end
            ACT_DEL_FIRST: begin
              if (count_r == '0) begin
                st_nxt = ST_EMPTY;
              end else begin
                at_nxt    = '0;
                ptr_nxt   = CNT_W'(1);
                state_nxt = S_SHDN;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SEARCH: begin
        if (hit) begin
          if (act_r == ACT_DEL_VALUE) begin
            at_nxt    = pend_addr_r;
            ptr_nxt   = CNT_W'(pend_addr_r) + 1'b1;
            state_nxt = S_SHDN;
          end else if (full) begin
            st_nxt    = ST_FULL;
            state_nxt = S_RESP;
          end else begin
            at_nxt    = (act_r == ACT_INS_AFTER) ? pend_addr_r + 1'b1 : pend_addr_r;
            ptr_nxt   = count_r;
            state_nxt = S_SHUP;
          end
        end else if (ptr_r < count_r) begin
          rd_en         = 1'b1;
          rd_addr       = ADDR_W'(ptr_r);
          pend_vld_nxt  = 1'b1;
          pend_addr_nxt = ADDR_W'(ptr_r);
          ptr_nxt       = ptr_r + 1'b1;
        end else if (!pend_vld_r) begin
          st_nxt    = ST_NOTFOUND;
          state_nxt = S_RESP;
        end
      end

      S_SHUP: begin
        if (pend_vld_r) begin
          wr_en   = 1'b1;
          wr_addr = pend_addr_r + 1'b1;
          wr_data = rd_data;
        end
        if (ptr_r > CNT_W'(at_r)) begin
          rd_en         = 1'b1;
          rd_addr       = ADDR_W'(ptr_r - 1'b1);
          pend_vld_nxt  = 1'b1;
          pend_addr_nxt = ADDR_W'(ptr_r - 1'b1);
          ptr_nxt       = ptr_r - 1'b1;
        end else if (!pend_vld_r) begin
          wr_en     = 1'b1;
          wr_addr   = at_r;
          wr_data   = val_r;
          count_nxt = count_r + 1'b1;
          where_nxt = at_r;
          state_nxt = S_RESP;
        end
      end

      S_SHDN: begin
        if (pend_vld_r) begin
          wr_en   = 1'b1;
          wr_addr = pend_addr_r - 1'b1;
          wr_data = rd_data;
        end
        if (ptr_r < count_r) begin
          rd_en         = 1'b1;
          rd_addr       = ADDR_W'(ptr_r);
          pend_vld_nxt  = 1'b1;
          pend_addr_nxt = ADDR_W'(ptr_r);
          ptr_nxt       = ptr_r + 1'b1;
        end else if (!pend_vld_r) begin
          count_nxt = count_r - 1'b1;
          where_nxt = at_r;
          state_nxt = S_RESP;
        end
      end

      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt         = 1'b1;
          out_rsp_nxt.status    = st_r;
          out_rsp_nxt.new_count = NCOUNT_W'(count_r);
          out_rsp_nxt.where     = WHERE_W'(where_r);
          state_nxt             = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ptr_r       <= ptr_nxt;
    at_r        <= at_nxt;
    pend_addr_r <= pend_addr_nxt;
    act_r       <= act_nxt;
    val_r       <= val_nxt;
    skey_r      <= skey_nxt;
    st_r        <= st_nxt;
    where_r     <= where_nxt;
    out_rsp_r   <= out_rsp_nxt;
  end

  `OAID_ASSERT_IMP(a_count_max, 1'b1, count_r <= CNT_W'(DEPTH), "count above depth")
  `OAID_ASSERT_IMP(a_wr_in_list, wr_en, CNT_W'(wr_addr) <= count_r, "write beyond list end")
  `OAID_ASSERT_IMP(a_shup_room, state_r == S_SHUP, count_r < CNT_W'(DEPTH), "shift up when full")
  `OAID_ASSERT_IMP(a_shdn_nonempty, state_r == S_SHDN, count_r != '0, "shift down when empty")
  `OAID_ASSERT_NXT(a_count_step, 1'b1,
    (count_r == $past(count_r)) || (count_r == $past(count_r) + 1'b1) ||
    (count_r == $past(count_r) - 1'b1),
    "count moved by more than one")

endmodule

// File: tb/tb_ordered_array_insert_delete.sv
// ----------------------------------------------------------------------------
// tb_ordered_array_insert_delete
// Self-checking bench for the ordered array block. Requests are predicted
// against a local copy of the packed list, and each response is matched
// field by field in order. Directed edge cases are followed by random fill
// and drain phases under varying sender idle and receiver stall, including
// one long receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb_ordered_array_insert_delete;
  import oaid_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 4'd9;
  localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 4'd15;
  localparam int HOLD_CYCLES = 2000;
  localparam int DRAIN_CYCLES = 2 * DEPTH + 40;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  in_req_t  in_req = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  out_rsp_t out_rsp;

  ordered_array_insert_delete dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rsp   (out_rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  in_req_t     pending_reqs[$];
  out_rsp_t    expected_rsps[$];
  word_t       list_mem [DEPTH];
  int unsigned list_cnt = 0;
  int unsigned fail_cnt = 0;
  int unsigned in_idle_pct = 0;
  int unsigned out_stall_pct = 0;
  bit          req_taken = 1'b0;
  bit          hold_go = 1'b0;
  bit          hold_on = 1'b0;

  function automatic int unsigned find_first(word_t k);
    int unsigned i;
    i = 0;
    while (i < list_cnt && list_mem[i] != k) i++;
    return i;
  endfunction

  function automatic void open_gap(int unsigned at, word_t w);
    int unsigned i;
    for (i = list_cnt; i > at; i--) list_mem[i] = list_mem[i-1];
    list_mem[at] = w;
    list_cnt++;
  endfunction

  function automatic void close_gap(int unsigned at);
    int unsigned i;
    for (i = at; i + 1 < list_cnt; i++) list_mem[i] = list_mem[i+1];
    list_cnt--;
  endfunction

  function automatic out_rsp_t apply_cmd(in_req_t r);
    out_rsp_t    rsp;
    status_t     st;
    int unsigned at;
    int unsigned idx;
    int unsigned pos;
    bit          full;
    st = ST_OK;
    at = 0;
    pos = 32'(r.position);
    full = (list_cnt >= DEPTH);
    case (r.action)
      ACT_INS_END: begin
        if (full) st = ST_FULL;
        else begin
          at = list_cnt;
          open_gap(list_cnt, r.value);
        end
      end
      ACT_INS_FRONT: begin
        if (full) st = ST_FULL;
        else open_gap(0, r.value);
      end
      ACT_INS_BEFORE, ACT_INS_AFTER: begin
        idx = find_first(r.key);
        if (idx >= list_cnt) st = ST_NOTFOUND;
        else if (full) st = ST_FULL;
        else begin
          if (r.action == ACT_INS_AFTER) idx++;
          at = idx;
          open_gap(idx, r.value);
        end
      end
      ACT_INS_AT: begin
        if (full) st = ST_FULL;
        else if (pos > list_cnt) st = ST_BADPOS;
        else begin
          at = pos;
          open_gap(pos, r.value);
        end
      end
      ACT_DEL_VALUE: begin
        idx = find_first(r.value);
        if (idx >= list_cnt) st = ST_NOTFOUND;
        else begin
          at = idx;
          close_gap(idx);
        end
      end
      ACT_DEL_AT: begin
        if (pos >= list_cnt) st = ST_BADPOS;
        else begin
          at = pos;
          close_gap(pos);
        end
      end
      ACT_DEL_LAST: begin
        if (list_cnt == 0) st = ST_EMPTY;
        else begin
          at = list_cnt - 1;
          list_cnt--;
        end
      end
      ACT_DEL_FIRST: begin
        if (list_cnt == 0) st = ST_EMPTY;
        else close_gap(0);
      end
      default: ;
    endcase
    if (st != ST_OK) at = 0;
    rsp.status = st;
    rsp.new_count = list_cnt[NCOUNT_W-1:0];
    rsp.where = at[WHERE_W-1:0];
    return rsp;
  endfunction

  function automatic word_t pick_word();
    if ($urandom_range(99) < 80) return word_t'(int'($urandom_range(15)) - 8);
    return word_t'($urandom);
  endfunction

  function automatic in_req_t rand_cmd(int unsigned ins_pct);
    in_req_t     r;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 3) r.action = action_t'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO));
    else if ($urandom_range(99) < ins_pct)
      r.action = action_t'($urandom_range(ACT_INS_AT, ACT_INS_END));
    else r.action = action_t'($urandom_range(ACT_DEL_FIRST, ACT_DEL_VALUE));
    r.value = pick_word();
    r.key = pick_word();
    roll = $urandom_range(99);
    if (roll < 70) r.position = POS_W'($urandom_range(DEPTH + 2));
    else if (roll < 85) r.position = POS_W'($urandom_range(8));
    else r.position = POS_W'($urandom_range(255));
    return r;
  endfunction

  task automatic queue_cmd(logic [ACTION_W-1:0] a, logic [FIELD_W-1:0] v,
                           logic [FIELD_W-1:0] k, logic [POS_W-1:0] p);
    in_req_t r;
    r.action = action_t'(a);
    r.value = v;
    r.key = k;
    r.position = p;
    pending_reqs.push_back(r);
  endtask

  task automatic run_phase(int unsigned idle, int unsigned stall, int unsigned ins_pct,
                           int unsigned n, bit hold);
    @(posedge clk);
    in_idle_pct = idle;
    out_stall_pct = stall;
    if (hold) hold_go = 1'b1;
    repeat (n) pending_reqs.push_back(rand_cmd(ins_pct));
    while (pending_reqs.size() != 0) @(posedge clk);
  endtask

  // driver: hold the request until taken, then advance
  always @(negedge clk) begin
    if (!in_valid || req_taken) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
        in_req <= pending_reqs.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= !hold_on && ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk) begin : monitor
    out_rsp_t want;
    if (!rst_n) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= in_valid && in_ready;
      if (in_valid && in_ready) expected_rsps.push_back(apply_cmd(in_req));
      if (out_valid && out_ready) begin
        if (expected_rsps.size() == 0) begin
          $error("response with no request outstanding");
          fail_cnt++;
        end else begin
          want = expected_rsps.pop_front();
          if (out_rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_rsp.status);
            fail_cnt++;
          end
          if (out_rsp.new_count !== want.new_count) begin
            $error("new_count: expected %0d, got %0d", want.new_count, out_rsp.new_count);
            fail_cnt++;
          end
          if (out_rsp.where !== want.where) begin
            $error("where: expected %0d, got %0d", want.where, out_rsp.where);
            fail_cnt++;
          end
        end
      end
    end
  end

  initial begin : receiver_hold
    wait (hold_go);
    @(posedge clk);
    hold_on = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on = 1'b0;
  end

  initial begin : watchdog
    #(64'd20_000_000);
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);
    // empty list
    queue_cmd(ACT_DEL_LAST, 0, 0, 0);
    queue_cmd(ACT_DEL_FIRST, 0, 0, 0);
    queue_cmd(ACT_DEL_AT, 0, 0, 0);
    queue_cmd(ACT_DEL_VALUE, 5, 0, 0);
    queue_cmd(ACT_INS_BEFORE, 1, 5, 0);
    queue_cmd(ACT_INS_AFTER, 1, 5, 0);
    queue_cmd(ACT_INS_AT, 1, 0, 1);
    queue_cmd(ACT_SPARE_HI, 32'hffff_ffff, 32'hffff_ffff, 8'hff);
    // build and edit a short list
    queue_cmd(ACT_INS_AT, 32'h8000_0000, 0, 0);
    queue_cmd(ACT_INS_END, 32'h7fff_ffff, 0, 0);
    queue_cmd(ACT_INS_FRONT, 32'hffff_ffff, 0, 0);
    queue_cmd(ACT_INS_BEFORE, 0, 32'h7fff_ffff, 0);
    queue_cmd(ACT_INS_AFTER, 1, 32'h7fff_ffff, 0);
    queue_cmd(ACT_INS_END, 32'hffff_ffff, 0, 0);
    queue_cmd(ACT_INS_BEFORE, 2, 32'hffff_ffff, 0);
    queue_cmd(ACT_INS_AT, 3, 0, 7);
    queue_cmd(ACT_INS_AT, 4, 0, 8'hff);
    queue_cmd(ACT_DEL_AT, 0, 0, 8'hff);
    queue_cmd(ACT_DEL_AT, 0, 0, 7);
    queue_cmd(ACT_DEL_VALUE, 32'h8000_0000, 0, 0);
    queue_cmd(ACT_DEL_VALUE, 32'h1234_5678, 0, 0);
    queue_cmd(ACT_INS_BEFORE, 9, 32'h1234_5678, 0);
    queue_cmd(ACT_DEL_LAST, 0, 0, 0);
    queue_cmd(ACT_DEL_FIRST, 0, 0, 0);
    queue_cmd(ACT_SPARE_LO, 0, 0, 0);
    while (pending_reqs.size() != 0) @(posedge clk);

    run_phase(0, 0, 85, 200, 1'b0);
    run_phase(63, 0, 50, 100, 1'b0);
    run_phase(0, 63, 15, 200, 1'b0);
    run_phase(18, 18, 60, 150, 1'b0);
    run_phase(0, 0, 50, 100, 1'b1);

    @(negedge clk);
    while (in_valid || hold_on || expected_rsps.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_cnt == 0 && expected_rsps.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hdl
hdl/oaid_pkg.sv
hdl/oaid_ram.sv
hdl/ordered_array_insert_delete.sv
tb/tb_ordered_array_insert_delete.sv
